/* rtl/s2ip_pkg.sv */
// Shared types, character codes and the specifier tables of the format translator.
`timescale 1ns / 1ps
`default_nettype none

package s2ip_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PCT    = 8'h25;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DANGLING = 2'd1;
	localparam logic [1:0] ST_BAD_SPEC = 2'd2;

	localparam int unsigned TEXT_BYTES = 24;

	typedef enum logic [1:0] {
		BODY_LIT  = 2'd0,
		BODY_ESC  = 2'd1,
		BODY_SPEC = 2'd2,
		BODY_ERR  = 2'd3
	} body_kind_t;

	// One queued command: everything the back end needs to expand one source byte.
	typedef struct packed {
		logic       open_q;
		logic       close_pre;
		logic       close_post;
		logic       eos;
		logic       warn;
		logic [1:0] status;
		body_kind_t kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] idx;
	} spec_hit_t;

	typedef struct packed {
		logic                       approx;
		logic [4:0]                 len;
		logic [TEXT_BYTES*8-1:0]    text;
	} spec_entry_t;

	function automatic spec_hit_t spec_index(input logic [7:0] c);
		spec_hit_t r;
		r.hit = 1'b1;
		case (c)
			"U": r.idx = 6'd0;
			"W": r.idx = 6'd1;
			"g": r.idx = 6'd2;
			"G": r.idx = 6'd3;
			"a": r.idx = 6'd4;
			"A": r.idx = 6'd5;
			"b": r.idx = 6'd6;
			"B": r.idx = 6'd7;
			"c": r.idx = 6'd8;
			"d": r.idx = 6'd9;
			"D": r.idx = 6'd10;
			"e": r.idx = 6'd11;
			"F": r.idx = 6'd12;
			"h": r.idx = 6'd13;
			"H": r.idx = 6'd14;
			"I": r.idx = 6'd15;
			"j": r.idx = 6'd16;
			"m": r.idx = 6'd17;
			"M": r.idx = 6'd18;
			"n": r.idx = 6'd19;
			"p": r.idx = 6'd20;
			"r": r.idx = 6'd21;
			"R": r.idx = 6'd22;
			"S": r.idx = 6'd23;
			"t": r.idx = 6'd24;
			"T": r.idx = 6'd25;
			"u": r.idx = 6'd26;
			"V": r.idx = 6'd27;
			"w": r.idx = 6'd28;
			"x": r.idx = 6'd29;
			"X": r.idx = 6'd30;
			"y": r.idx = 6'd31;
			"Y": r.idx = 6'd32;
			"z": r.idx = 6'd33;
			"Z": r.idx = 6'd34;
			default: begin
				r.hit = 1'b0;
				r.idx = 6'd0;
			end
		endcase
		return r;
	endfunction

	// Text is right-aligned: the first character sits in the highest used byte.
	function automatic spec_entry_t spec_entry(input logic [5:0] idx);
		spec_entry_t e;
		e.approx = 1'b0;
		e.len    = 5'd2;
		e.text   = '0;
		case (idx)
			6'd0:  begin e.approx = 1'b1; e.text = "ww"; end
			6'd1:  begin e.text = "ww"; end
			6'd2:  begin e.approx = 1'b1; e.text = "yy"; end
			6'd3:  begin e.approx = 1'b1; e.len = 5'd1; e.text = "Y"; end
			6'd4:  begin e.len = 5'd3; e.text = "ccc"; end
			6'd5:  begin e.len = 5'd4; e.text = "cccc"; end
			6'd6:  begin e.len = 5'd3; e.text = "MMM"; end
			6'd7:  begin e.len = 5'd4; e.text = "MMMM"; end
			6'd8:  begin
				e.approx = 1'b1;
				e.len    = 5'd23;
				e.text   = "eee MMM d HH:mm:ss yyyy";
			end
			6'd9:  begin e.text = "dd"; end
			6'd10: begin e.len = 5'd8; e.text = "MM/dd/yy"; end
			6'd11: begin e.len = 5'd1; e.text = "d"; end
			6'd12: begin e.len = 5'd10; e.text = "yyyy-MM-dd"; end
			6'd13: begin e.len = 5'd3; e.text = "MMM"; end
			6'd14: begin e.text = "HH"; end
			6'd15: begin e.text = "hh"; end
			6'd16: begin e.len = 5'd1; e.text = "D"; end
			6'd17: begin e.text = "MM"; end
			6'd18: begin e.text = "mm"; end
			6'd19: begin e.len = 5'd1; e.text = "\n"; end
			6'd20: begin e.len = 5'd1; e.text = "a"; end
			6'd21: begin e.approx = 1'b1; e.len = 5'd8; e.text = "hh:mm:ss"; end
			6'd22: begin e.len = 5'd5; e.text = "HH:mm"; end
			6'd23: begin e.text = "ss"; end
			6'd24: begin e.len = 5'd1; e.text = "\t"; end
			6'd25: begin e.len = 5'd8; e.text = "HH:mm:ss"; end
			6'd26: begin e.approx = 1'b1; e.len = 5'd1; e.text = "c"; end
			6'd27: begin e.approx = 1'b1; e.text = "ww"; end
			6'd28: begin e.approx = 1'b1; e.len = 5'd1; e.text = "c"; end
			6'd29: begin e.approx = 1'b1; e.len = 5'd8; e.text = "yy/MM/dd"; end
			6'd30: begin e.approx = 1'b1; e.len = 5'd8; e.text = "HH:mm:ss"; end
			6'd31: begin e.text = "yy"; end
			6'd32: begin e.len = 5'd4; e.text = "yyyy"; end
			6'd33: begin e.len = 5'd1; e.text = "Z"; end
			6'd34: begin e.len = 5'd1; e.text = "z"; end
			default: begin e.len = 5'd1; end
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

/* rtl/s2ip_front.sv */
// Front end: takes source bytes, tracks the quote, percent and failure flags, issues commands.
`timescale 1ns / 1ps
`default_nettype none

module s2ip_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [7:0]     in_byte,
	input  wire logic           last_in_string,
	input  wire logic           full,
	output logic                push,
	output s2ip_pkg::cmd_t      cmd
);

	logic quote_open_q, percent_pending_q, string_failed_q;
	logic quote_open_d, percent_pending_d, string_failed_d;
	logic accept, err, emits;
	s2ip_pkg::spec_hit_t   lk;
	s2ip_pkg::spec_entry_t ent;

	assign in_stall = full;
	assign accept   = in_valid & ~full;
	assign lk       = s2ip_pkg::spec_index(in_byte);
	assign ent      = s2ip_pkg::spec_entry(lk.idx);

	always_comb begin
		cmd               = '0;
		cmd.kind          = s2ip_pkg::BODY_LIT;
		cmd.status        = s2ip_pkg::ST_OK;
		emits             = 1'b0;
		err               = 1'b0;
		quote_open_d      = quote_open_q;
		percent_pending_d = percent_pending_q;
		string_failed_d   = string_failed_q;
		if (string_failed_q) begin
			if (last_in_string) begin
				quote_open_d      = 1'b0;
				percent_pending_d = 1'b0;
				string_failed_d   = 1'b0;
			end
		end else begin
			if (percent_pending_q) begin
				percent_pending_d = 1'b0;
				emits             = 1'b1;
				if (in_byte == s2ip_pkg::CH_PCT) begin
					cmd.open_q   = ~quote_open_q;
					cmd.data     = s2ip_pkg::CH_PCT;
					quote_open_d = 1'b1;
				end else if (lk.hit) begin
					cmd.close_pre = quote_open_q;
					cmd.kind      = s2ip_pkg::BODY_SPEC;
					cmd.data      = {2'b00, lk.idx};
					cmd.warn      = ent.approx;
					quote_open_d  = 1'b0;
				end else begin
					cmd.kind   = s2ip_pkg::BODY_ERR;
					cmd.status = s2ip_pkg::ST_BAD_SPEC;
					err        = 1'b1;
				end
			end else if (in_byte == s2ip_pkg::CH_QUOTE) begin
				emits        = 1'b1;
				cmd.open_q   = ~quote_open_q;
				cmd.kind     = s2ip_pkg::BODY_ESC;
				quote_open_d = 1'b1;
			end else if (in_byte == s2ip_pkg::CH_PCT) begin
				if (last_in_string) begin
					emits      = 1'b1;
					cmd.kind   = s2ip_pkg::BODY_ERR;
					cmd.status = s2ip_pkg::ST_DANGLING;
					err        = 1'b1;
				end else begin
					percent_pending_d = 1'b1;
				end
			end else begin
				emits        = 1'b1;
				cmd.open_q   = ~quote_open_q;
				cmd.data     = in_byte;
				quote_open_d = 1'b1;
			end

			if (err) begin
				cmd.eos = 1'b1;
				if (last_in_string) begin
					quote_open_d      = 1'b0;
					percent_pending_d = 1'b0;
				end else begin
					string_failed_d = 1'b1;
				end
			end else if (last_in_string) begin
				// Any run still open is closed after the body.
				cmd.close_post    = quote_open_d;
				cmd.eos           = 1'b1;
				quote_open_d      = 1'b0;
				percent_pending_d = 1'b0;
			end
		end
	end

	assign push = accept & emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_open_q      <= 1'b0;
			percent_pending_q <= 1'b0;
			string_failed_q   <= 1'b0;
		end else if (accept) begin
			quote_open_q      <= quote_open_d;
			percent_pending_q <= percent_pending_d;
			string_failed_q   <= string_failed_d;
		end
	end

	// A failed string has already consumed its percent, so both flags never coexist.
	a_pending_not_failed: assert property (@(posedge clk) disable iff (!arst_n)
		!(percent_pending_q && string_failed_q))
		else $error("percent pending while string failed");

endmodule

`default_nettype wire

/* rtl/s2ip_fifo.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module s2ip_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  s2ip_pkg::cmd_t       wr_data,
	input  wire logic            pop,
	output s2ip_pkg::cmd_t       rd_data,
	output logic                 full,
	output logic                 empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	s2ip_pkg::cmd_t entries_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("command queue underflow");

endmodule

`default_nettype wire

/* rtl/s2ip_back.sv */
// Back end: expands one queued command into result beats through a registered output.
`timescale 1ns / 1ps
`default_nettype none

module s2ip_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  s2ip_pkg::cmd_t      cmd,
	input  wire logic           empty,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                end_of_string,
	output logic [1:0]          status,
	output logic                warn
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_PRE  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_POST = 4'b1000
	} phase_t;

	phase_t                phase_q;
	s2ip_pkg::cmd_t        cur_q;
	logic [4:0]            pos_q;
	s2ip_pkg::spec_entry_t ent;
	logic [4:0]            body_len, sel;
	logic                  body_last, final_item, adv, load;
	logic [7:0]            item_byte;

	logic                  out_valid_q, eos_q, warn_q;
	logic [7:0]            byte_q;
	logic [1:0]            status_q;

	assign ent = s2ip_pkg::spec_entry(cur_q.data[5:0]);
	assign sel = 5'(ent.len - 5'd1 - pos_q);

	always_comb begin
		case (cur_q.kind)
			s2ip_pkg::BODY_ESC:  body_len = 5'd2;
			s2ip_pkg::BODY_SPEC: body_len = ent.len;
			default:             body_len = 5'd1;
		endcase
	end

	assign body_last  = (pos_q == 5'(body_len - 5'd1));
	assign final_item = (phase_q == PH_POST) ||
		((phase_q == PH_BODY) && body_last && !cur_q.close_post);

	always_comb begin
		item_byte = s2ip_pkg::CH_QUOTE;
		if (phase_q == PH_BODY) begin
			case (cur_q.kind)
				s2ip_pkg::BODY_LIT:  item_byte = cur_q.data;
				s2ip_pkg::BODY_ESC:
					item_byte = (pos_q == '0) ? s2ip_pkg::CH_BSLASH : s2ip_pkg::CH_QUOTE;
				s2ip_pkg::BODY_SPEC: item_byte = ent.text[{sel, 3'b000} +: 8];
				default:             item_byte = 8'h00;
			endcase
		end
	end

	assign adv  = (phase_q != PH_IDLE) && (!out_valid_q || !out_stall);
	assign load = ((phase_q == PH_IDLE) || (adv && final_item)) && !empty;
	assign pop  = load;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd;
		end
		if (adv) begin
			byte_q   <= item_byte;
			eos_q    <= final_item & cur_q.eos;
			status_q <= cur_q.status;
			warn_q   <= cur_q.warn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (load) begin
				phase_q <= (cmd.open_q || cmd.close_pre) ? PH_PRE : PH_BODY;
				pos_q   <= '0;
			end else if (adv) begin
				case (phase_q)
					PH_PRE: begin
						phase_q <= PH_BODY;
						pos_q   <= '0;
					end
					PH_BODY: begin
						if (!body_last) begin
							pos_q <= pos_q + 5'd1;
						end else if (cur_q.close_post) begin
							phase_q <= PH_POST;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
					default: phase_q <= PH_IDLE;
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign end_of_string = eos_q;
	assign status        = status_q;
	assign warn          = warn_q;

	// An error beat is always a lone zero byte that closes its string.
	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != s2ip_pkg::ST_OK) |-> (out_byte == 8'h00 && end_of_string))
		else $error("error beat malformed");

	a_body_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (pos_q < body_len))
		else $error("body position beyond expansion length");

endmodule

`default_nettype wire

/* rtl/strftime_to_icu_pattern_translator.sv */
// A taken byte is written into the command queue and loaded by the expansion unit,
// which drives its beats through the output register. Throughput: one result beat
// per cycle while out_stall is low; a byte gives 0 to 24 beats, 1 to 3 for plain text.
// Source bytes are taken one per cycle while the command queue has room.
// Reset clears the string flags, the command queue and the output valid flag at once.
`timescale 1ns / 1ps
`default_nettype none

module strftime_to_icu_pattern_translator #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        last_in_string,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             end_of_string,
	output logic [1:0]       status,
	output logic             warn
);

	s2ip_pkg::cmd_t push_cmd, pop_cmd;
	logic           push, pop, full, empty;

	s2ip_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.last_in_string (last_in_string),
		.full           (full),
		.push           (push),
		.cmd            (push_cmd)
	);

	s2ip_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_cmd),
		.pop     (pop),
		.rd_data (pop_cmd),
		.full    (full),
		.empty   (empty)
	);

	s2ip_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (pop_cmd),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.end_of_string (end_of_string),
		.status        (status),
		.warn          (warn)
	);

endmodule

`default_nettype wire
